>>> design/wifi_link_supervisor_macros.svh
// Assertion macros shared by the link supervisor checkers.
`ifndef WIFI_LINK_SUPERVISOR_MACROS_SVH
`define WIFI_LINK_SUPERVISOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define WLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after reset is applied.
`define WLS_ASSERT_RST(label, cons, msg) \
    label: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) else $error(msg);

`endif

>>> design/wls_pkg.sv
// Types, constants and register defaults of the link supervisor.
`timescale 1ns / 1ps

package wls_pkg;

    // Station link phases
    typedef enum logic [1:0] {
        PH_PROV = 2'd0,
        PH_CONN = 2'd1,
        PH_UP   = 2'd2,
        PH_WAIT = 2'd3
    } t_link_phase;

    // Access point phases
    typedef enum logic [1:0] {
        AP_OFF  = 2'd0,
        AP_ON   = 2'd1,
        AP_WAIT = 2'd2
    } t_ap_phase;

    // Lifecycle events
    typedef enum logic [1:0] {
        EV_CONNECTING = 2'd0,
        EV_CONNECTED  = 2'd1,
        EV_DISABLED   = 2'd2,
        EV_ERROR      = 2'd3
    } t_event;

    // Radio modes
    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_STA  = 2'd1,
        MODE_AP   = 2'd2,
        MODE_BOTH = 2'd3
    } t_mode;

    // Request operations
    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STA_CREDS     = 3'd0,
        CFG_STA_TIMEOUT   = 3'd1,
        CFG_STA_RETRY     = 3'd2,
        CFG_FALLBACK_DLY  = 3'd3,
        CFG_AP_RETRY      = 3'd4,
        CFG_AP_IDLE       = 3'd5
    } t_cfg_idx;

    // Disconnect reasons that end an attempt immediately
    localparam logic [15:0] RSN_AUTH_EXPIRE   = 16'd2;
    localparam logic [15:0] RSN_ASSOC_EXPIRE  = 16'd4;
    localparam logic [15:0] RSN_HANDSHAKE_TO  = 16'd15;
    localparam logic [15:0] RSN_AUTH_FAIL_8021X = 16'd23;
    localparam logic [15:0] RSN_BEACON_TO     = 16'd201;
    localparam logic [15:0] RSN_NO_AP         = 16'd202;
    localparam logic [15:0] RSN_AUTH_FAIL     = 16'd203;
    localparam logic [15:0] RSN_ASSOC_FAIL    = 16'd204;

    typedef struct packed {
        logic        sta_credentials_present;
        logic [31:0] sta_attempt_timeout_ms;
        logic [31:0] sta_retry_interval_ms;
        logic [31:0] fallback_ap_delay_ms;
        logic [31:0] ap_retry_interval_ms;
        logic [31:0] ap_idle_timeout_ms;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        sta_credentials_present: 1'b1,
        sta_attempt_timeout_ms:  32'd15000,
        sta_retry_interval_ms:   32'd5000,
        fallback_ap_delay_ms:    32'd30000,
        ap_retry_interval_ms:    32'd5000,
        ap_idle_timeout_ms:      32'd300000
    };

    typedef struct packed {
        logic        operation;
        logic [31:0] now_ms;
        logic        link_up;
        logic        disconnect_seen;
        logic [15:0] disconnect_reason;
        logic        ap_start_ok;
        logic        ap_has_clients;
    } t_in_item;

    typedef struct packed {
        logic       event_valid;
        logic [1:0] event_code;
        logic       mode_write;
        logic [1:0] mode_value;
        logic       ap_start_cmd;
        logic       ap_stop_cmd;
        logic       sta_begin_cmd;
        logic       sta_drop_cmd;
        logic [1:0] link_phase;
        logic [1:0] ap_phase;
    } t_out_item;

    typedef struct packed {
        t_link_phase link_phase;
        t_ap_phase   ap_phase;
        logic        credentials_latched;
        logic        campaign_active;
        logic        fallback_requested;
        logic        accepting_disconnects;
        logic [31:0] campaign_start_time;
        logic [31:0] attempt_start_time;
        logic [31:0] retry_start_time;
        logic [31:0] ap_activity_time;
        logic [31:0] ap_retry_time;
    } t_state;

    localparam t_state STATE_RESET = '{
        link_phase: PH_PROV,
        ap_phase:   AP_OFF,
        default:    '0
    };

endpackage

>>> design/wls_in_if.sv
// Request channel carrying one supervisor input item.
`timescale 1ns / 1ps

interface wls_in_if import wls_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/wls_out_if.sv
// Result channel carrying one supervisor result item.
`timescale 1ns / 1ps

interface wls_out_if import wls_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/wifi_link_supervisor.sv
// Top level of the station link supervisor with fallback access point.
// One request (start or tick) is taken per clock while the output is not
// stalled, and gives exactly one result. A request is registered, evaluated
// combinationally by the step logic, and its result lands in the output
// register once the output frees; the state registers update in that same
// cycle, so the next request sees it at once. A result waiting in the output
// register lets one more request into the input register; further requests are
// refused until the output frees. The sustained rate is one request per cycle as
// long as results are taken. Configuration writes take effect on the next clock
// and are meant for when no request is in flight.
`timescale 1ns / 1ps

module wifi_link_supervisor import wls_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    wls_in_if.sink                i_in,
    wls_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      cfg;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_state    r_state;
    t_state    n_state;
    t_out_item n_out_item;
    logic      out_free;
    logic      step_fire;

    wls_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    wls_step u_step (
        .i_item   (r_in_item),
        .i_state  (r_state),
        .i_cfg    (cfg),
        .o_state  (n_state),
        .o_result (n_out_item)
    );

    // Handshake: the output register frees when empty or being taken
    assign out_free   = !r_out_valid || o_out.ready;
    assign step_fire  = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (step_fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.data;
        end
        if (step_fire) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

endmodule

>>> design/wls_cfg_regs.sv
// Configuration register file, written through a plain write port.
`timescale 1ns / 1ps

module wls_cfg_regs import wls_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Register writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_STA_CREDS:    r_cfg.sta_credentials_present <= i_cfg_data[0];
                CFG_STA_TIMEOUT:  r_cfg.sta_attempt_timeout_ms  <= i_cfg_data;
                CFG_STA_RETRY:    r_cfg.sta_retry_interval_ms   <= i_cfg_data;
                CFG_FALLBACK_DLY: r_cfg.fallback_ap_delay_ms    <= i_cfg_data;
                CFG_AP_RETRY:     r_cfg.ap_retry_interval_ms    <= i_cfg_data;
                CFG_AP_IDLE:      r_cfg.ap_idle_timeout_ms      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/wls_step.sv
// Single-pass step logic: next supervisor state and result for one request.
`timescale 1ns / 1ps

module wls_step import wls_pkg::*; (
    input  t_in_item  i_item,
    input  t_state    i_state,
    input  t_cfg      i_cfg,
    output t_state    o_state,
    output t_out_item o_result
);

    // Wrap-safe elapsed check
    function automatic logic f_passed(logic [31:0] now, logic [31:0] since,
                                      logic [31:0] interval);
        logic [31:0] diff;
        diff = now - since;
        return diff >= interval;
    endfunction

    // First event of the step wins
    function automatic void f_raise(inout t_out_item res, input t_event code);
        if (!res.event_valid) begin
            res.event_valid = 1'b1;
            res.event_code  = code;
        end
    endfunction

    function automatic void f_write_mode(inout t_out_item res, input t_mode m);
        res.mode_write = 1'b1;
        res.mode_value = m;
    endfunction

    function automatic void f_ap_request(inout t_state st, inout t_out_item res,
                                         input logic [31:0] now, input logic ok);
        if (st.ap_phase != AP_ON) begin
            res.ap_start_cmd = 1'b1;
            if (ok) begin
                st.ap_phase         = AP_ON;
                st.ap_activity_time = now;
            end else begin
                st.ap_phase      = AP_WAIT;
                st.ap_retry_time = now;
            end
        end
    endfunction

    function automatic void f_ap_shutdown(inout t_state st, inout t_out_item res);
        if (st.ap_phase != AP_OFF) begin
            if (st.ap_phase == AP_ON) begin
                res.ap_stop_cmd = 1'b1;
            end
            st.ap_phase = AP_OFF;
            f_write_mode(res, st.credentials_latched ? MODE_STA : MODE_OFF);
        end
    endfunction

    function automatic void f_campaign_begin(inout t_state st, input logic [31:0] now);
        st.campaign_active     = 1'b1;
        st.fallback_requested  = 1'b0;
        st.campaign_start_time = now;
    endfunction

    function automatic void f_attempt_begin(inout t_state st, inout t_out_item res,
                                            input logic [31:0] now);
        if (st.link_phase != PH_CONN) begin
            if (!st.credentials_latched) begin
                st.link_phase = PH_PROV;
            end else begin
                st.attempt_start_time    = now;
                st.link_phase            = PH_CONN;
                st.accepting_disconnects = 1'b1;
                f_raise(res, EV_CONNECTING);
                res.sta_begin_cmd = 1'b1;
            end
        end
    endfunction

    function automatic void f_link_established(inout t_state st, inout t_out_item res);
        st.accepting_disconnects = 1'b0;
        st.link_phase            = PH_UP;
        st.campaign_active       = 1'b0;
        f_ap_shutdown(st, res);
        f_raise(res, EV_CONNECTED);
    endfunction

    function automatic void f_attempt_failed(inout t_state st, inout t_out_item res,
                                             input logic [31:0] now, input logic drop);
        st.accepting_disconnects = 1'b0;
        st.link_phase            = PH_WAIT;
        st.retry_start_time      = now;
        if (drop) begin
            res.sta_drop_cmd = 1'b1;
        end
        f_raise(res, EV_ERROR);
    endfunction

    function automatic logic f_fast_fail(logic [15:0] r);
        return r == RSN_AUTH_EXPIRE || r == RSN_ASSOC_EXPIRE ||
               r == RSN_HANDSHAKE_TO || r == RSN_AUTH_FAIL_8021X ||
               r == RSN_BEACON_TO || r == RSN_NO_AP ||
               r == RSN_AUTH_FAIL || r == RSN_ASSOC_FAIL;
    endfunction

    // Raise the AP in dual mode once the campaign has run too long
    function automatic void f_fallback_check(inout t_state st, inout t_out_item res,
                                             input logic [31:0] now, input logic link,
                                             input logic ok, input logic [31:0] delay);
        if (st.campaign_active && !st.fallback_requested && !link &&
            f_passed(now, st.campaign_start_time, delay)) begin
            st.fallback_requested = 1'b1;
            f_write_mode(res, MODE_BOTH);
            f_ap_request(st, res, now, ok);
        end
    endfunction

    t_state    st;
    t_out_item res;
    logic      pending;
    logic      cfg_bad;

    // One start or tick, applied in order
    always_comb begin
        st      = i_state;
        res     = '0;
        pending = i_item.disconnect_seen && (i_state.link_phase == PH_CONN) &&
                  i_state.accepting_disconnects;
        cfg_bad = (i_cfg.sta_retry_interval_ms == '0) ||
                  (i_cfg.ap_retry_interval_ms == '0) ||
                  (i_cfg.ap_idle_timeout_ms == '0) ||
                  (i_cfg.sta_attempt_timeout_ms == '0) ||
                  (i_cfg.fallback_ap_delay_ms == '0);

        if (i_item.operation == OP_START) begin
            // Start: reset, validate timing, pick initial mode
            st.link_phase            = PH_PROV;
            st.ap_phase              = AP_OFF;
            st.accepting_disconnects = 1'b0;
            st.credentials_latched   = 1'b0;
            st.campaign_active       = 1'b0;
            st.fallback_requested    = 1'b0;
            if (cfg_bad) begin
                f_raise(res, EV_ERROR);
            end else begin
                st.credentials_latched = i_cfg.sta_credentials_present;
                if (!i_cfg.sta_credentials_present) begin
                    f_write_mode(res, MODE_AP);
                    f_ap_request(st, res, i_item.now_ms, i_item.ap_start_ok);
                    f_raise(res, EV_DISABLED);
                end else begin
                    f_write_mode(res, MODE_STA);
                    f_campaign_begin(st, i_item.now_ms);
                    f_attempt_begin(st, res, i_item.now_ms);
                end
            end
        end else begin
            // Tick: station link phases
            case (i_state.link_phase)
                PH_CONN: begin
                    if (i_item.link_up) begin
                        f_link_established(st, res);
                    end else if (pending && f_fast_fail(i_item.disconnect_reason)) begin
                        f_attempt_failed(st, res, i_item.now_ms, 1'b0);
                    end else if (f_passed(i_item.now_ms, st.attempt_start_time,
                                          i_cfg.sta_attempt_timeout_ms)) begin
                        f_attempt_failed(st, res, i_item.now_ms, 1'b1);
                    end
                    f_fallback_check(st, res, i_item.now_ms, i_item.link_up,
                                     i_item.ap_start_ok, i_cfg.fallback_ap_delay_ms);
                end
                PH_UP: begin
                    if (!i_item.link_up) begin
                        res.sta_drop_cmd = 1'b1;
                        f_campaign_begin(st, i_item.now_ms);
                        st.link_phase       = PH_WAIT;
                        st.retry_start_time = i_item.now_ms;
                    end
                end
                PH_WAIT: begin
                    f_fallback_check(st, res, i_item.now_ms, i_item.link_up,
                                     i_item.ap_start_ok, i_cfg.fallback_ap_delay_ms);
                    if (i_item.link_up) begin
                        f_link_established(st, res);
                    end else if (f_passed(i_item.now_ms, st.retry_start_time,
                                          i_cfg.sta_retry_interval_ms)) begin
                        f_attempt_begin(st, res, i_item.now_ms);
                    end
                end
                default: begin
                end
            endcase

            // AP start retry
            if (st.link_phase != PH_UP && !i_item.link_up && st.ap_phase == AP_WAIT &&
                f_passed(i_item.now_ms, st.ap_retry_time, i_cfg.ap_retry_interval_ms)) begin
                f_ap_request(st, res, i_item.now_ms, i_item.ap_start_ok);
            end

            // AP idle shutdown
            if (st.credentials_latched && st.campaign_active && !i_item.link_up &&
                st.ap_phase == AP_ON) begin
                if (i_item.ap_has_clients) begin
                    st.ap_activity_time = i_item.now_ms;
                end else if (f_passed(i_item.now_ms, st.ap_activity_time,
                                      i_cfg.ap_idle_timeout_ms)) begin
                    f_ap_shutdown(st, res);
                end
            end
        end

        res.link_phase = st.link_phase;
        res.ap_phase   = st.ap_phase;
    end

    assign o_state  = st;
    assign o_result = res;

endmodule

>>> design/wls_checker.sv
// Port-level checker for the link supervisor, bound to the top level.
`timescale 1ns / 1ps
`include "wifi_link_supervisor_macros.svh"

module wls_checker import wls_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    // Reset empties the result register
    `WLS_ASSERT_RST(a_rst_empty, !i_out_valid, "result valid after reset")

    // A stalled result holds
    `WLS_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "stalled result changed")

    // Requests are refused only behind a stalled result
    `WLS_ASSERT_NOW(a_in_backpressure, !i_in_ready, i_out_valid && !i_out_ready, "request refused without output stall")

    // An AP stop leaves the AP inactive
    `WLS_ASSERT_NOW(a_stop_off, i_out_valid && i_out_data.ap_stop_cmd, i_out_data.ap_phase == AP_OFF, "AP stop with AP not inactive")

    // A station begin reports connecting
    `WLS_ASSERT_NOW(a_begin_conn, i_out_valid && i_out_data.sta_begin_cmd, i_out_data.link_phase == PH_CONN && i_out_data.event_valid && i_out_data.event_code == EV_CONNECTING, "station begin without connecting")

endmodule

bind wifi_link_supervisor wls_checker u_wls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

>>> test/wifi_link_supervisor_tb.sv
// Self-checking testbench for the station link supervisor with fallback access point.
`timescale 1ns / 1ps

module wifi_link_supervisor_tb;
    import wls_pkg::*;

    localparam int RANDOM_REQS = 1100;
    localparam int SETTLE_CYCLES = 6;

    typedef struct {
        t_in_item req;
        bit       drain;
    } t_pending;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    wls_in_if  in_ch ();
    wls_out_if out_ch ();

    wifi_link_supervisor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    t_pending  req_backlog[$];
    t_out_item expected_results[$];
    bit        in_fire;
    int        gap_left;
    int        stall_left;
    bit        src_burst;
    bit        sink_burst;
    int        random_reqs;
    int        mismatch_count;

    // ------------------------------------------------------------------
    // Supervisor predictor: mirrored state, registers and the result being built
    // ------------------------------------------------------------------
    t_state      sup;
    t_cfg        cfg_mirror;
    t_out_item   res;
    logic [31:0] step_now;
    bit          link_now;
    bit          ap_ok_now;
    bit          clients_now;

    // wrap-safe interval test
    function automatic bit elapsed(logic [31:0] since, logic [31:0] interval);
        logic [31:0] diff;
        diff = step_now - since;
        return diff >= interval;
    endfunction

    // first event of a step wins
    function automatic void note_event(t_event code);
        if (res.event_valid) return;
        res.event_valid = 1'b1;
        res.event_code  = code;
    endfunction

    function automatic void set_mode(logic [1:0] m);
        res.mode_write = 1'b1;
        res.mode_value = m;
    endfunction

    function automatic void raise_ap();
        if (sup.ap_phase == AP_ON) return;
        res.ap_start_cmd = 1'b1;
        if (ap_ok_now) begin
            sup.ap_phase         = AP_ON;
            sup.ap_activity_time = step_now;
        end else begin
            sup.ap_phase      = AP_WAIT;
            sup.ap_retry_time = step_now;
        end
    endfunction

    function automatic void drop_ap();
        if (sup.ap_phase == AP_OFF) return;
        if (sup.ap_phase == AP_ON) res.ap_stop_cmd = 1'b1;
        sup.ap_phase = AP_OFF;
        set_mode(sup.credentials_latched ? MODE_STA : MODE_OFF);
    endfunction

    function automatic void open_campaign();
        sup.campaign_active     = 1'b1;
        sup.fallback_requested  = 1'b0;
        sup.campaign_start_time = step_now;
    endfunction

    function automatic void begin_attempt();
        if (sup.link_phase == PH_CONN) return;
        if (!sup.credentials_latched) begin
            sup.link_phase = PH_PROV;
            return;
        end
        sup.attempt_start_time    = step_now;
        sup.link_phase            = PH_CONN;
        sup.accepting_disconnects = 1'b1;
        note_event(EV_CONNECTING);
        res.sta_begin_cmd = 1'b1;
    endfunction

    function automatic void link_made();
        sup.accepting_disconnects = 1'b0;
        sup.link_phase            = PH_UP;
        sup.campaign_active       = 1'b0;
        drop_ap();
        note_event(EV_CONNECTED);
    endfunction

    function automatic void attempt_lost(bit drop);
        sup.accepting_disconnects = 1'b0;
        sup.link_phase            = PH_WAIT;
        sup.retry_start_time      = step_now;
        if (drop) res.sta_drop_cmd = 1'b1;
        note_event(EV_ERROR);
    endfunction

    function automatic bit is_fast_fail(logic [15:0] r);
        return r == RSN_AUTH_EXPIRE || r == RSN_ASSOC_EXPIRE || r == RSN_HANDSHAKE_TO ||
               r == RSN_AUTH_FAIL_8021X || r == RSN_BEACON_TO || r == RSN_NO_AP ||
               r == RSN_AUTH_FAIL || r == RSN_ASSOC_FAIL;
    endfunction

    // raise the AP in dual mode once a campaign has run too long
    function automatic void check_fallback();
        if (!sup.campaign_active || sup.fallback_requested || link_now) return;
        if (!elapsed(sup.campaign_start_time, cfg_mirror.fallback_ap_delay_ms)) return;
        sup.fallback_requested = 1'b1;
        set_mode(MODE_BOTH);
        raise_ap();
    endfunction

    function automatic void start_supervisor();
        sup.link_phase            = PH_PROV;
        sup.ap_phase              = AP_OFF;
        sup.accepting_disconnects = 1'b0;
        sup.credentials_latched   = 1'b0;
        sup.campaign_active       = 1'b0;
        sup.fallback_requested    = 1'b0;
        if (cfg_mirror.sta_retry_interval_ms == 0 || cfg_mirror.ap_retry_interval_ms == 0 ||
            cfg_mirror.ap_idle_timeout_ms == 0 || cfg_mirror.sta_attempt_timeout_ms == 0 ||
            cfg_mirror.fallback_ap_delay_ms == 0) begin
            note_event(EV_ERROR);
            return;
        end
        sup.credentials_latched = cfg_mirror.sta_credentials_present;
        if (!sup.credentials_latched) begin
            set_mode(MODE_AP);
            raise_ap();
            note_event(EV_DISABLED);
        end else begin
            set_mode(MODE_STA);
            open_campaign();
            begin_attempt();
        end
    endfunction

    function automatic void tick_supervisor(bit disc_seen, logic [15:0] reason);
        bit disc_pending;
        disc_pending = disc_seen && sup.link_phase == PH_CONN && sup.accepting_disconnects;
        case (sup.link_phase)
            PH_CONN: begin
                if (link_now) begin
                    link_made();
                end else if (disc_pending && is_fast_fail(reason)) begin
                    attempt_lost(1'b0);
                end else if (elapsed(sup.attempt_start_time,
                                     cfg_mirror.sta_attempt_timeout_ms)) begin
                    attempt_lost(1'b1);
                end
                check_fallback();
            end
            PH_UP: begin
                if (!link_now) begin
                    res.sta_drop_cmd = 1'b1;
                    open_campaign();
                    sup.link_phase       = PH_WAIT;
                    sup.retry_start_time = step_now;
                end
            end
            PH_WAIT: begin
                check_fallback();
                if (link_now) link_made();
                else if (elapsed(sup.retry_start_time, cfg_mirror.sta_retry_interval_ms))
                    begin_attempt();
            end
            default: ;
        endcase

        // retry of a failed AP start
        if (sup.link_phase != PH_UP && !link_now && sup.ap_phase == AP_WAIT &&
            elapsed(sup.ap_retry_time, cfg_mirror.ap_retry_interval_ms))
            raise_ap();

        // idle AP shutdown during a campaign
        if (sup.credentials_latched && sup.campaign_active && !link_now &&
            sup.ap_phase == AP_ON) begin
            if (clients_now) sup.ap_activity_time = step_now;
            else if (elapsed(sup.ap_activity_time, cfg_mirror.ap_idle_timeout_ms)) drop_ap();
        end
    endfunction

    function automatic t_out_item supervise_step(t_in_item req);
        res         = '0;
        step_now    = req.now_ms;
        link_now    = req.link_up;
        ap_ok_now   = req.ap_start_ok;
        clients_now = req.ap_has_clients;
        if (req.operation == OP_START) start_supervisor();
        else tick_supervisor(req.disconnect_seen, req.disconnect_reason);
        res.link_phase = sup.link_phase;
        res.ap_phase   = sup.ap_phase;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_interval();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 32'd0;
        if (r < 8) return 32'hFFFF_FFFF;
        if (r < 14) return 32'd1;
        if (r < 25) return $urandom_range(3000, 20000);
        return $urandom_range(50, 3000);
    endfunction

    function automatic logic [31:0] pick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 1500);
        if (r < 90) return $urandom_range(1500, 8000);
        if (r < 97) return $urandom_range(0, 400000);
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_reason();
        if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 7))
            0: return RSN_AUTH_EXPIRE;
            1: return RSN_ASSOC_EXPIRE;
            2: return RSN_HANDSHAKE_TO;
            3: return RSN_AUTH_FAIL_8021X;
            4: return RSN_BEACON_TO;
            5: return RSN_NO_AP;
            6: return RSN_AUTH_FAIL;
            default: return RSN_ASSOC_FAIL;
        endcase
    endfunction

    function automatic void queue_req(t_op op, logic [31:0] at, bit link, bit disc,
                                      logic [15:0] reason, bit ok, bit clients, bit drain);
        t_pending p;
        p.req.operation         = op;
        p.req.now_ms            = at;
        p.req.link_up           = link;
        p.req.disconnect_seen   = disc;
        p.req.disconnect_reason = reason;
        p.req.ap_start_ok       = ok;
        p.req.ap_has_clients    = clients;
        p.drain                 = drain;
        req_backlog.push_back(p);
    endfunction

    // ------------------------------------------------------------------
    // Configuration writes, only while nothing is in flight
    // ------------------------------------------------------------------
    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_STA_CREDS:    cfg_mirror.sta_credentials_present = val[0];
            CFG_STA_TIMEOUT:  cfg_mirror.sta_attempt_timeout_ms  = val;
            CFG_STA_RETRY:    cfg_mirror.sta_retry_interval_ms   = val;
            CFG_FALLBACK_DLY: cfg_mirror.fallback_ap_delay_ms    = val;
            CFG_AP_RETRY:     cfg_mirror.ap_retry_interval_ms    = val;
            CFG_AP_IDLE:      cfg_mirror.ap_idle_timeout_ms      = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_cfg(t_cfg c);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(CFG_STA_CREDS, {junk[31:1], c.sta_credentials_present});
        write_reg(CFG_STA_TIMEOUT, c.sta_attempt_timeout_ms);
        write_reg(CFG_STA_RETRY, c.sta_retry_interval_ms);
        write_reg(CFG_FALLBACK_DLY, c.fallback_ap_delay_ms);
        write_reg(CFG_AP_RETRY, c.ap_retry_interval_ms);
        write_reg(CFG_AP_IDLE, c.ap_idle_timeout_ms);
    endtask

    // wait for every request to be taken and answered, then let the pipe settle
    task automatic wait_idle();
        while (req_backlog.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            gap_left    <= 0;
        end else if (!in_ch.valid || in_fire) begin
            if ($urandom_range(0, 199) == 0) src_burst <= !src_burst;
            if (gap_left != 0) begin
                in_ch.valid <= 1'b0;
                gap_left    <= gap_left - 1;
            end else if (req_backlog.size() != 0 &&
                         !(req_backlog[0].drain && expected_results.size() != 0)) begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= req_backlog[0].req;
                req_backlog.delete(0);
                gap_left    <= (!src_burst && $urandom_range(0, 2) == 0) ? idle_len() : 0;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result back-pressure
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) sink_burst <= !sink_burst;
        if (stall_left != 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            out_ch.ready <= 1'b1;
            if (!sink_burst && $urandom_range(0, 3) == 0) stall_left <= idle_len();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted request, check each accepted result
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [1:0] want, logic [1:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            in_fire = 1'b0;
        end else begin
            in_fire = in_ch.valid && in_ch.ready;
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, got %h", $time, got);
                end else begin
                    want = expected_results.pop_front();
                    check_field("event_valid", want.event_valid, got.event_valid);
                    check_field("event_code", want.event_code, got.event_code);
                    check_field("mode_write", want.mode_write, got.mode_write);
                    check_field("mode_value", want.mode_value, got.mode_value);
                    check_field("ap_start_cmd", want.ap_start_cmd, got.ap_start_cmd);
                    check_field("ap_stop_cmd", want.ap_stop_cmd, got.ap_stop_cmd);
                    check_field("sta_begin_cmd", want.sta_begin_cmd, got.sta_begin_cmd);
                    check_field("sta_drop_cmd", want.sta_drop_cmd, got.sta_drop_cmd);
                    check_field("link_phase", want.link_phase, got.link_phase);
                    check_field("ap_phase", want.ap_phase, got.ap_phase);
                end
            end
            if (in_fire) expected_results.push_back(supervise_step(in_ch.data));
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        t_cfg        c;
        logic [31:0] clock_ms;
        bit          link;
        int          n;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        sup          = STATE_RESET;
        cfg_mirror   = CFG_RESET;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: full station lifecycle across a time wrap
        queue_req(OP_TICK, 32'd0, 0, 0, 16'd0, 0, 0, 0);                 // tick before start
        queue_req(OP_START, 32'hFFFF_F000, 0, 0, 16'd0, 1, 0, 0);
        queue_req(OP_TICK, 32'hFFFF_FFFF, 0, 1, 16'hFFFF, 0, 0, 0);      // unrelated reason
        queue_req(OP_TICK, 32'hFFFF_FFFF, 0, 1, RSN_AUTH_EXPIRE, 0, 0, 0); // fast fail
        queue_req(OP_TICK, 32'h0000_1800, 0, 0, 16'd0, 0, 0, 0);         // retry after wrap
        queue_req(OP_TICK, 32'h0001_0000, 0, 0, 16'd0, 0, 0, 0);         // timeout, fallback fails
        queue_req(OP_TICK, 32'h0001_2000, 0, 0, 16'd0, 1, 0, 0);         // AP retry succeeds
        queue_req(OP_TICK, 32'h0001_3000, 0, 0, 16'd0, 1, 1, 0);
        queue_req(OP_TICK, 32'h0006_0000, 0, 0, 16'd0, 1, 0, 0);         // idle AP stops
        queue_req(OP_TICK, 32'h0006_0010, 1, 0, 16'd0, 0, 0, 0);
        queue_req(OP_TICK, 32'h0006_0020, 1, 1, RSN_NO_AP, 0, 1, 0);
        queue_req(OP_TICK, 32'h0006_0030, 0, 0, 16'd0, 0, 0, 0);         // link lost
        wait_idle();

        // no credentials: access point only
        c = CFG_RESET;
        c.sta_credentials_present = 1'b0;
        load_cfg(c);
        queue_req(OP_START, 32'd1000, 0, 0, 16'd0, 1, 0, 0);
        queue_req(OP_TICK, 32'd400000, 0, 0, 16'd0, 0, 0, 0);
        queue_req(OP_START, 32'd500000, 0, 0, 16'd0, 0, 0, 0);
        queue_req(OP_TICK, 32'd505000, 0, 0, 16'd0, 1, 0, 0);
        wait_idle();

        // zero interval at start
        c = CFG_RESET;
        c.sta_retry_interval_ms = '0;
        load_cfg(c);
        queue_req(OP_START, 32'd10, 0, 0, 16'd0, 1, 0, 0);
        wait_idle();

        // zero intervals after start: two AP attempts in one step, then a rejected start
        load_cfg(CFG_RESET);
        queue_req(OP_START, 32'd100, 0, 0, 16'd0, 0, 0, 0);
        wait_idle();
        c = CFG_RESET;
        c.fallback_ap_delay_ms = '0;
        c.ap_retry_interval_ms = '0;
        c.ap_idle_timeout_ms   = '0;
        load_cfg(c);
        queue_req(OP_TICK, 32'd200, 0, 0, 16'd0, 0, 0, 0);
        queue_req(OP_START, 32'd300, 0, 0, 16'd0, 1, 0, 0);
        wait_idle();

        // fallback mode and idle stop in one step
        load_cfg(CFG_RESET);
        queue_req(OP_START, 32'd400, 0, 0, 16'd0, 1, 0, 0);
        wait_idle();
        c = CFG_RESET;
        c.fallback_ap_delay_ms = '0;
        c.ap_idle_timeout_ms   = '0;
        load_cfg(c);
        queue_req(OP_TICK, 32'd500, 0, 0, 16'd0, 1, 0, 0);
        wait_idle();

        // largest intervals
        c = '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        load_cfg(c);
        queue_req(OP_START, 32'hFFFF_FFFF, 0, 0, 16'd0, 1, 0, 0);
        queue_req(OP_TICK, 32'd0, 0, 1, 16'hFFFF, 1, 1, 0);

        // random sessions: new registers, usually a start, then a run of ticks with occasional starts
        clock_ms = $urandom;
        link     = 1'b0;
        while (random_reqs < RANDOM_REQS) begin
            wait_idle();
            c.sta_credentials_present = ($urandom_range(0, 4) != 0);
            c.sta_attempt_timeout_ms  = pick_interval();
            c.sta_retry_interval_ms   = pick_interval();
            c.fallback_ap_delay_ms    = pick_interval();
            c.ap_retry_interval_ms    = pick_interval();
            c.ap_idle_timeout_ms      = pick_interval();
            load_cfg(c);
            if ($urandom_range(0, 9) != 0) begin
                queue_req(OP_START, clock_ms, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 0);
                random_reqs++;
            end
            n = $urandom_range(10, 40);
            repeat (n) begin
                clock_ms += pick_step();
                if ($urandom_range(0, 4) == 0) link = !link;
                queue_req(($urandom_range(0, 99) < 3) ? OP_START : OP_TICK, clock_ms, link,
                          ($urandom_range(0, 3) == 0), pick_reason(),
                          ($urandom_range(0, 9) < 6), ($urandom_range(0, 9) < 4),
                          ($urandom_range(0, 99) == 0));
                random_reqs++;
            end
        end
        wait_idle();

        if (mismatch_count == 0) begin
            $display("wifi_link_supervisor regression: pass");
        end else begin
            $display("wifi_link_supervisor regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #8_000_000;
        $display("wifi_link_supervisor regression: fail");
        $finish;
    end

endmodule
